/* sv/cau_pkg.sv */
`default_nettype none

package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} cau_kind_t;

	// Per-request control that rides along the pipeline
	typedef struct packed {
		logic valid;
		logic is_div;
		logic div_by_zero;
		logic alt_sat;
	} cau_ctrl_t;

endpackage

`default_nettype wire

/* sv/cau_front.sv */
`default_nettype none

module cau_front #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [1:0]                    kind,
	input  wire logic signed [DATA_WIDTH-1:0]  a_re,
	input  wire logic signed [DATA_WIDTH-1:0]  a_im,
	input  wire logic signed [DATA_WIDTH-1:0]  b_re,
	input  wire logic signed [DATA_WIDTH-1:0]  b_im,
	output cau_pkg::cau_ctrl_t                 ctrl,
	output logic [DATA_WIDTH-1:0]              alt_re,
	output logic [DATA_WIDTH-1:0]              alt_im,
	output logic                               neg_re,
	output logic                               neg_im,
	output logic [2*DATA_WIDTH-1:0]            mag_re,
	output logic [2*DATA_WIDTH-1:0]            mag_im,
	output logic [2*DATA_WIDTH-1:0]            den
);

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 1;

	localparam logic signed [SW-1:0] SAT_MAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_MIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

	// Stage 1: products and plain sums
	logic                    valid_s1;
	cau_pkg::cau_kind_t      kind_s1;
	logic signed [PW-1:0]    p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [PW-1:0]    sq_rr_s1, sq_ii_s1;
	logic signed [W:0]       as_re_s1, as_im_s1;

	logic signed [W:0] ext_ar, ext_ai, ext_br, ext_bi;
	assign ext_ar = {a_re[W-1], a_re};
	assign ext_ai = {a_im[W-1], a_im};
	assign ext_br = {b_re[W-1], b_re};
	assign ext_bi = {b_im[W-1], b_im};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= cau_pkg::cau_kind_t'(kind);
			p_rr_s1  <= a_re * b_re;
			p_ii_s1  <= a_im * b_im;
			p_ri_s1  <= a_re * b_im;
			p_ir_s1  <= a_im * b_re;
			sq_rr_s1 <= b_re * b_re;
			sq_ii_s1 <= b_im * b_im;
			if (cau_pkg::cau_kind_t'(kind) == cau_pkg::KIND_SUB) begin
				as_re_s1 <= ext_ar - ext_br;
				as_im_s1 <= ext_ai - ext_bi;
			end else begin
				as_re_s1 <= ext_ar + ext_br;
				as_im_s1 <= ext_ai + ext_bi;
			end
		end
	end

	// Stage 2: combine products by operation, form denominator
	logic                    valid_s2;
	cau_pkg::cau_kind_t      kind_s2;
	logic signed [SW-1:0]    sum_re_s2, sum_im_s2;
	logic [PW-1:0]           den_s2;

	logic signed [SW-1:0] x_rr, x_ii, x_ri, x_ir, x_as_re, x_as_im;
	assign x_rr    = {p_rr_s1[PW-1], p_rr_s1};
	assign x_ii    = {p_ii_s1[PW-1], p_ii_s1};
	assign x_ri    = {p_ri_s1[PW-1], p_ri_s1};
	assign x_ir    = {p_ir_s1[PW-1], p_ir_s1};
	assign x_as_re = {{(SW-W-1){as_re_s1[W]}}, as_re_s1};
	assign x_as_im = {{(SW-W-1){as_im_s1[W]}}, as_im_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			den_s2  <= $unsigned(sq_rr_s1) + $unsigned(sq_ii_s1);
			unique case (kind_s1)
				cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
					sum_re_s2 <= x_as_re;
					sum_im_s2 <= x_as_im;
				end
				cau_pkg::KIND_MUL: begin
					sum_re_s2 <= x_rr - x_ii;
					sum_im_s2 <= x_ri + x_ir;
				end
				cau_pkg::KIND_DIV: begin
					sum_re_s2 <= x_rr + x_ii;
					sum_im_s2 <= x_ir - x_ri;
				end
				default: begin
					sum_re_s2 <= x_as_re;
					sum_im_s2 <= x_as_im;
				end
			endcase
		end
	end

	// Stage 3: finish add/sub/mul with saturation, split quotient numerators
	logic signed [SW-1:0] v_re, v_im, abs_re, abs_im;
	logic                 sat_re, sat_im;
	logic [W-1:0]         clip_re, clip_im;

	assign v_re = (kind_s2 == cau_pkg::KIND_MUL) ? (sum_re_s2 >>> FRAC_BITS) : sum_re_s2;
	assign v_im = (kind_s2 == cau_pkg::KIND_MUL) ? (sum_im_s2 >>> FRAC_BITS) : sum_im_s2;

	always_comb begin
		sat_re  = 1'b0;
		clip_re = v_re[W-1:0];
		if (v_re > SAT_MAX) begin
			sat_re  = 1'b1;
			clip_re = SAT_MAX[W-1:0];
		end else if (v_re < SAT_MIN) begin
			sat_re  = 1'b1;
			clip_re = SAT_MIN[W-1:0];
		end
		sat_im  = 1'b0;
		clip_im = v_im[W-1:0];
		if (v_im > SAT_MAX) begin
			sat_im  = 1'b1;
			clip_im = SAT_MAX[W-1:0];
		end else if (v_im < SAT_MIN) begin
			sat_im  = 1'b1;
			clip_im = SAT_MIN[W-1:0];
		end
	end

	assign abs_re = sum_re_s2[SW-1] ? -sum_re_s2 : sum_re_s2;
	assign abs_im = sum_im_s2[SW-1] ? -sum_im_s2 : sum_im_s2;

	cau_pkg::cau_ctrl_t ctrl_s3;
	logic [W-1:0]       alt_re_s3, alt_im_s3;
	logic               neg_re_s3, neg_im_s3;
	logic [PW-1:0]      mag_re_s3, mag_im_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s3.valid       <= valid_s2;
			ctrl_s3.is_div      <= (kind_s2 == cau_pkg::KIND_DIV);
			ctrl_s3.div_by_zero <= (kind_s2 == cau_pkg::KIND_DIV) && (den_s2 == '0);
			ctrl_s3.alt_sat     <= sat_re | sat_im;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alt_re_s3           <= clip_re;
			alt_im_s3           <= clip_im;
			neg_re_s3           <= sum_re_s2[SW-1];
			neg_im_s3           <= sum_im_s2[SW-1];
			mag_re_s3           <= abs_re[PW-1:0];
			mag_im_s3           <= abs_im[PW-1:0];
			den_s3              <= den_s2;
		end
	end

	assign ctrl   = ctrl_s3;
	assign alt_re = alt_re_s3;
	assign alt_im = alt_im_s3;
	assign neg_re = neg_re_s3;
	assign neg_im = neg_im_s3;
	assign mag_re = mag_re_s3;
	assign mag_im = mag_im_s3;
	assign den    = den_s3;

endmodule

`default_nettype wire

/* sv/cau_div_step.sv */
`default_nettype none

// One restoring-division step for both lanes; quotient bits shift in at the
// bottom of ql while dividend bits leave at the top.
module cau_div_step #(
	parameter int DW = 32,
	parameter int QW = 16,
	parameter int PW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [DW-1:0] den_i,
	input  wire logic [DW-1:0] r_re_i,
	input  wire logic [DW-1:0] r_im_i,
	input  wire logic [QW-1:0] ql_re_i,
	input  wire logic [QW-1:0] ql_im_i,
	input  wire logic [PW-1:0] pay_i,
	output logic [DW-1:0]      den_o,
	output logic [DW-1:0]      r_re_o,
	output logic [DW-1:0]      r_im_o,
	output logic [QW-1:0]      ql_re_o,
	output logic [QW-1:0]      ql_im_o,
	output logic [PW-1:0]      pay_o
);

	logic [DW:0] t_re, t_im, d_ext, n_re, n_im;
	logic        ge_re, ge_im;

	assign d_ext = {1'b0, den_i};
	assign t_re  = {r_re_i, ql_re_i[QW-1]};
	assign t_im  = {r_im_i, ql_im_i[QW-1]};
	assign ge_re = (t_re >= d_ext);
	assign ge_im = (t_im >= d_ext);
	assign n_re  = ge_re ? (t_re - d_ext) : t_re;
	assign n_im  = ge_im ? (t_im - d_ext) : t_im;

	logic [DW-1:0] den_s1, r_re_s1, r_im_s1;
	logic [QW-1:0] ql_re_s1, ql_im_s1;
	logic [PW-1:0] pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_s1 <= '0;
		end else if (en) begin
			pay_s1 <= pay_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1   <= den_i;
			r_re_s1  <= n_re[DW-1:0];
			r_im_s1  <= n_im[DW-1:0];
			ql_re_s1 <= {ql_re_i[QW-2:0], ge_re};
			ql_im_s1 <= {ql_im_i[QW-2:0], ge_im};
		end
	end

	assign den_o   = den_s1;
	assign r_re_o  = r_re_s1;
	assign r_im_o  = r_im_s1;
	assign ql_re_o = ql_re_s1;
	assign ql_im_o = ql_im_s1;
	assign pay_o   = pay_s1;

endmodule

`default_nettype wire

/* sv/complex_arithmetic_unit_core.sv */
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// operands in signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction bits).
//
// Input channel: in_valid/in_ready with kind, a_re, a_im, b_re, b_im.
// Output channel: out_valid/out_ready with res_re, res_im, div_by_zero and
// saturated. Each request gives exactly one result, in request order.
//
// From acceptance to out_valid every operation passes the same stages:
// three front stages for the multipliers, the operand combine and
// saturation, one divider setup stage, DATA_WIDTH restoring-division
// stages (one quotient bit each) and the output register. Throughput is
// one request per cycle while the receiver does not stall the pipeline.
//
// Reset clears every valid bit; the pipeline comes up empty. When the
// receiver holds out_ready low with a result waiting, the whole pipeline
// freezes and in_ready drops in the same cycle; nothing is lost or repeated.
// Division by 0+0i returns 0+0i with div_by_zero set.

`default_nettype none

module complex_arithmetic_unit_core #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   kind,
	input  wire logic signed [DATA_WIDTH-1:0] a_re,
	input  wire logic signed [DATA_WIDTH-1:0] a_im,
	input  wire logic signed [DATA_WIDTH-1:0] b_re,
	input  wire logic signed [DATA_WIDTH-1:0] b_im,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0]      res_re,
	output logic signed [DATA_WIDTH-1:0]      res_im,
	output logic                              div_by_zero,
	output logic                              saturated
);

	localparam int W  = DATA_WIDTH;
	localparam int DW = 2 * W;
	localparam int NW = 2 * W + FRAC_BITS;
	localparam int HW = W + FRAC_BITS;
	localparam int CW = (HW > DW) ? HW : DW;
	localparam int CTW = $bits(cau_pkg::cau_ctrl_t);
	// payload: ctrl, neg_re, neg_im, ovf_re, ovf_im, alt_re, alt_im
	localparam int PAYW = CTW + 4 + 2 * W;

	// Advance everything unless a finished result is still waiting
	logic out_valid_q;
	logic en;
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	// Front: multiply, combine, saturate the non-divide results
	cau_pkg::cau_ctrl_t f_ctrl;
	logic [W-1:0]       f_alt_re, f_alt_im;
	logic               f_neg_re, f_neg_im;
	logic [DW-1:0]      f_mag_re, f_mag_im, f_den;

	cau_front #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.kind     (kind),
		.a_re     (a_re),
		.a_im     (a_im),
		.b_re     (b_re),
		.b_im     (b_im),
		.ctrl     (f_ctrl),
		.alt_re   (f_alt_re),
		.alt_im   (f_alt_im),
		.neg_re   (f_neg_re),
		.neg_im   (f_neg_im),
		.mag_re   (f_mag_re),
		.mag_im   (f_mag_im),
		.den      (f_den)
	);

	// Divider setup: scale numerators by the fraction bits, and flag any
	// quotient of 2^W or more up front so only W quotient bits remain.
	logic [NW-1:0] n_re, n_im;
	logic [HW-1:0] hi_re, hi_im;
	logic [CW-1:0] hc_re, hc_im, dc;
	logic          ovf_re, ovf_im;

	assign n_re   = NW'(f_mag_re) << FRAC_BITS;
	assign n_im   = NW'(f_mag_im) << FRAC_BITS;
	assign hi_re  = n_re[NW-1:W];
	assign hi_im  = n_im[NW-1:W];
	assign hc_re  = CW'(hi_re);
	assign hc_im  = CW'(hi_im);
	assign dc     = CW'(f_den);
	assign ovf_re = (hc_re >= dc);
	assign ovf_im = (hc_im >= dc);

	logic [DW-1:0]   den_s4, r_re_s4, r_im_s4;
	logic [W-1:0]    ql_re_s4, ql_im_s4;
	logic [PAYW-1:0] pay_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_s4 <= '0;
		end else if (en) begin
			pay_s4 <= {f_ctrl, f_neg_re, f_neg_im, ovf_re, ovf_im, f_alt_re, f_alt_im};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4   <= f_den;
			r_re_s4  <= DW'(hc_re);
			r_im_s4  <= DW'(hc_im);
			ql_re_s4 <= n_re[W-1:0];
			ql_im_s4 <= n_im[W-1:0];
		end
	end

	// Division chain: one quotient bit per stage
	logic [DW-1:0]   c_den  [0:W];
	logic [DW-1:0]   c_r_re [0:W];
	logic [DW-1:0]   c_r_im [0:W];
	logic [W-1:0]    c_ql_re[0:W];
	logic [W-1:0]    c_ql_im[0:W];
	logic [PAYW-1:0] c_pay  [0:W];

	assign c_den[0]   = den_s4;
	assign c_r_re[0]  = r_re_s4;
	assign c_r_im[0]  = r_im_s4;
	assign c_ql_re[0] = ql_re_s4;
	assign c_ql_im[0] = ql_im_s4;
	assign c_pay[0]   = pay_s4;

	for (genvar k = 0; k < W; k++) begin : g_div
		cau_div_step #(
			.DW (DW),
			.QW (W),
			.PW (PAYW)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.den_i   (c_den[k]),
			.r_re_i  (c_r_re[k]),
			.r_im_i  (c_r_im[k]),
			.ql_re_i (c_ql_re[k]),
			.ql_im_i (c_ql_im[k]),
			.pay_i   (c_pay[k]),
			.den_o   (c_den[k+1]),
			.r_re_o  (c_r_re[k+1]),
			.r_im_o  (c_r_im[k+1]),
			.ql_re_o (c_ql_re[k+1]),
			.ql_im_o (c_ql_im[k+1]),
			.pay_o   (c_pay[k+1])
		);
	end

	// Unpack the payload at the end of the chain
	cau_pkg::cau_ctrl_t e_ctrl;
	logic               e_neg_re, e_neg_im, e_ovf_re, e_ovf_im;
	logic [W-1:0]       e_alt_re, e_alt_im, q_re, q_im;

	assign {e_ctrl, e_neg_re, e_neg_im, e_ovf_re, e_ovf_im, e_alt_re, e_alt_im} = c_pay[W];
	assign q_re = c_ql_re[W];
	assign q_im = c_ql_im[W];

	// Signed, saturated quotient: positive clips at 2^(W-1)-1, negative at -2^(W-1)
	localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

	logic [W-1:0] dq_re, dq_im;
	logic         dsat_re, dsat_im;

	always_comb begin
		if (e_neg_re) begin
			dsat_re = e_ovf_re || (q_re[W-1] && (|q_re[W-2:0]));
			dq_re   = dsat_re ? NEG_MIN : (~q_re + 1'b1);
		end else begin
			dsat_re = e_ovf_re || q_re[W-1];
			dq_re   = dsat_re ? POS_MAX : q_re;
		end
		if (e_neg_im) begin
			dsat_im = e_ovf_im || (q_im[W-1] && (|q_im[W-2:0]));
			dq_im   = dsat_im ? NEG_MIN : (~q_im + 1'b1);
		end else begin
			dsat_im = e_ovf_im || q_im[W-1];
			dq_im   = dsat_im ? POS_MAX : q_im;
		end
	end

	// Output register: pick the non-divide result, the quotient, or zero on a zero divisor
	logic [W-1:0] res_re_q, res_im_q;
	logic         dz_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= e_ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (!e_ctrl.is_div) begin
				res_re_q <= e_alt_re;
				res_im_q <= e_alt_im;
				dz_q     <= 1'b0;
				sat_q    <= e_ctrl.alt_sat;
			end else if (e_ctrl.div_by_zero) begin
				res_re_q <= '0;
				res_im_q <= '0;
				dz_q     <= 1'b1;
				sat_q    <= 1'b0;
			end else begin
				res_re_q <= dq_re;
				res_im_q <= dq_im;
				dz_q     <= 1'b0;
				sat_q    <= dsat_re | dsat_im;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign res_re      = res_re_q;
	assign res_im      = res_im_q;
	assign div_by_zero = dz_q;
	assign saturated   = sat_q;

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int DW           = cau_pkg::DATA_WIDTH_DEF;
	localparam int FB           = cau_pkg::FRAC_BITS_DEF;
	// Acceptance to out_valid: the front, setup, division and output stages
	localparam int PIPE_LATENCY = DW + 5;
	// Slowest legal run ends far below this limit
	localparam int RUN_LIMIT_NS = 4_000_000;

	// Receiver pacing levels
	localparam int STALL_NONE  = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;

	typedef struct {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic                 dz;
		logic                 sat;
	} cau_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [1:0]           kind;
	logic signed [DW-1:0] a_re;
	logic signed [DW-1:0] a_im;
	logic signed [DW-1:0] b_re;
	logic signed [DW-1:0] b_im;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [DW-1:0] res_re;
	logic signed [DW-1:0] res_im;
	logic                 div_by_zero;
	logic                 saturated;

	// Results predicted for accepted requests, oldest first
	cau_result_t pending_complex_results[$];
	int          mismatch_count = 0;
	bit          source_gaps_on = 1'b1;
	int          stall_level    = STALL_LIGHT;

	complex_arithmetic_unit_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.a_re        (a_re),
		.a_im        (a_im),
		.b_re        (b_re),
		.b_im        (b_im),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res_re      (res_re),
		.res_im      (res_im),
		.div_by_zero (div_by_zero),
		.saturated   (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the pipeline hangs or loses a result
	initial begin
		#(RUN_LIMIT_NS);
		$display("complex_arithmetic_unit_core regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction: exact wide intermediates, clip only the final parts
	// ------------------------------------------------------------------
	function automatic bit part_fits(input longint v);
		return v <= ((longint'(1) <<< (DW-1)) - 1) && v >= -(longint'(1) <<< (DW-1));
	endfunction

	function automatic logic signed [DW-1:0] clip_part(input longint v);
		longint lim_hi;
		longint lim_lo;
		lim_hi = (longint'(1) <<< (DW-1)) - 1;
		lim_lo = -(longint'(1) <<< (DW-1));
		if (v > lim_hi) begin
			v = lim_hi;
		end else if (v < lim_lo) begin
			v = lim_lo;
		end
		return v[DW-1:0];
	endfunction

	function automatic cau_result_t predict_complex(input cau_pkg::cau_kind_t op,
			input logic signed [DW-1:0] xr, xi, yr, yi);
		longint      pr, pi, qr, qi;
		longint      re_x, im_x, den;
		cau_result_t r;
		pr   = xr;
		pi   = xi;
		qr   = yr;
		qi   = yi;
		re_x = 0;
		im_x = 0;
		r.dz = 1'b0;
		unique case (op)
			cau_pkg::KIND_ADD: begin
				re_x = pr + qr;
				im_x = pi + qi;
			end
			cau_pkg::KIND_SUB: begin
				re_x = pr - qr;
				im_x = pi - qi;
			end
			cau_pkg::KIND_MUL: begin
				// arithmetic shift: rounds toward minus infinity
				re_x = (pr * qr - pi * qi) >>> FB;
				im_x = (pr * qi + pi * qr) >>> FB;
			end
			cau_pkg::KIND_DIV: begin
				den = qr * qr + qi * qi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					// signed division truncates toward zero
					re_x = ((pr * qr + pi * qi) * (longint'(1) <<< FB)) / den;
					im_x = ((pi * qr - pr * qi) * (longint'(1) <<< FB)) / den;
				end
			end
		endcase
		r.re  = clip_part(re_x);
		r.im  = clip_part(im_x);
		r.sat = !part_fits(re_x) || !part_fits(im_x);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Mostly back-to-back, some short gaps, a few long ones; none with gaps off
	function automatic int unsigned source_gap();
		int unsigned pick;
		pick = $urandom_range(99);
		if (!source_gaps_on || pick < 55) begin
			return 0;
		end else if (pick < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Mix full-range values, small magnitudes near zero and the extremes
	function automatic logic [DW-1:0] rand_operand();
		int unsigned pick;
		int          v;
		pick = $urandom_range(9);
		if (pick < 4) begin
			v = $urandom;
		end else if (pick < 7) begin
			v = int'($urandom_range(0, 1023)) - 512;
		end else if (pick == 7) begin
			return {1'b1, {(DW-1){1'b0}}};
		end else if (pick == 8) begin
			return {1'b0, {(DW-1){1'b1}}};
		end else begin
			v = int'($urandom_range(0, 2)) - 1;
		end
		return v[DW-1:0];
	endfunction

	// Present one request, hold it until accepted, record its prediction.
	// Call at a falling edge; return at a falling edge with in_valid still
	// high when no gap follows, so the next request drives straight on.
	task automatic send_request(input cau_pkg::cau_kind_t op,
			input logic [DW-1:0] xr, xi, yr, yi);
		cau_result_t want;
		int unsigned gap;
		want = predict_complex(op, xr, xi, yr, yi);
		kind     <= op;
		a_re     <= xr;
		a_im     <= xi;
		b_re     <= yr;
		b_im     <= yi;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_complex_results.push_back(want);
		@(negedge clk);
		gap = source_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random_request();
		cau_pkg::cau_kind_t op;
		logic [DW-1:0]      xr, xi, yr, yi;
		op = cau_pkg::cau_kind_t'($urandom_range(3));
		xr = rand_operand();
		xi = rand_operand();
		yr = rand_operand();
		yi = rand_operand();
		// force a zero divisor now and then
		if (op == cau_pkg::KIND_DIV && $urandom_range(99) < 6) begin
			yr = '0;
			yi = '0;
		end
		send_request(op, xr, xi, yr, yi);
	endtask

	// Drop valid and hold off until every predicted result has come back
	task automatic wait_pipeline_empty();
		in_valid <= 1'b0;
		while (pending_complex_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_corner_requests();
		// add/sub: clip high and low, plain values, cancellation
		send_request(cau_pkg::KIND_ADD, 16'h7fff, 16'h7fff, 16'h0001, 16'h0001);
		send_request(cau_pkg::KIND_ADD, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
		send_request(cau_pkg::KIND_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(cau_pkg::KIND_ADD, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_request(cau_pkg::KIND_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_request(cau_pkg::KIND_SUB, 16'h0100, 16'h0200, 16'h0080, 16'h0300);
		send_request(cau_pkg::KIND_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
		// mul: unity, floor of a negative fraction, extreme products
		send_request(cau_pkg::KIND_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
		send_request(cau_pkg::KIND_MUL, 16'h0001, 16'h0000, 16'hffff, 16'h0000);
		send_request(cau_pkg::KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_request(cau_pkg::KIND_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
		send_request(cau_pkg::KIND_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
		send_request(cau_pkg::KIND_MUL, 16'h0180, 16'hff80, 16'h0040, 16'h0200);
		// div: zero divisor, unit and tiny divisors, largest divisor
		send_request(cau_pkg::KIND_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
		send_request(cau_pkg::KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(cau_pkg::KIND_DIV, 16'h0100, 16'h0000, 16'h0001, 16'h0000);
		send_request(cau_pkg::KIND_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
		send_request(cau_pkg::KIND_DIV, 16'h0100, 16'h0100, 16'h0100, 16'h0000);
		// negative quotient must truncate toward zero
		send_request(cau_pkg::KIND_DIV, 16'hff00, 16'h0000, 16'h0300, 16'h0000);
		send_request(cau_pkg::KIND_DIV, 16'h0001, 16'h0000, 16'h7fff, 16'h7fff);
		send_request(cau_pkg::KIND_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0001);
		send_request(cau_pkg::KIND_DIV, 16'h0000, 16'h0100, 16'h0000, 16'h0100);
		send_request(cau_pkg::KIND_DIV, 16'h0100, 16'h0000, 16'hff00, 16'h0000);
		wait_pipeline_empty();
	endtask

	task automatic test_mixed_random();
		source_gaps_on = 1'b1;
		stall_level    = STALL_LIGHT;
		repeat (600) send_random_request();
	endtask

	// Full rate on both sides: no source gaps, receiver always ready
	task automatic test_back_to_back();
		source_gaps_on = 1'b0;
		stall_level    = STALL_NONE;
		repeat (250) send_random_request();
		source_gaps_on = 1'b1;
	endtask

	// Bursts separated by a full drain of the pipeline
	task automatic test_drain_pauses();
		stall_level = STALL_LIGHT;
		repeat (5) begin
			repeat (40) send_random_request();
			wait_pipeline_empty();
		end
	endtask

	// Receiver stalls often: exercise the pipeline freeze
	task automatic test_heavy_backpressure();
		stall_level = STALL_HEAVY;
		repeat (300) send_random_request();
	endtask

	// ------------------------------------------------------------------
	// Receiver pacing: ready runs, unless STALL_NONE, with stalls in between
	// ------------------------------------------------------------------
	initial begin : sink_pacing
		int unsigned run;
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_ready <= 1'b1;
			if (stall_level == STALL_HEAVY) begin
				run = $urandom_range(1, 3);
			end else if ($urandom_range(9) == 0) begin
				run = $urandom_range(20, 60);
			end else begin
				run = $urandom_range(1, 8);
			end
			repeat (run) @(negedge clk);
			if (stall_level != STALL_NONE) begin
				out_ready <= 1'b0;
				stall = ($urandom_range(9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
				repeat (stall) @(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result check: compare every accepted result with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		cau_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_complex_results.size() == 0) begin
				$error("result with no request pending: re %0d im %0d", res_re, res_im);
				mismatch_count++;
			end else begin
				want = pending_complex_results.pop_front();
				if (res_re !== want.re) begin
					$error("res_re: expected %0d, got %0d", want.re, res_re);
					mismatch_count++;
				end
				if (res_im !== want.im) begin
					$error("res_im: expected %0d, got %0d", want.im, res_im);
					mismatch_count++;
				end
				if (div_by_zero !== want.dz) begin
					$error("div_by_zero: expected %0b, got %0b", want.dz, div_by_zero);
					mismatch_count++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, saturated);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		kind      = cau_pkg::KIND_ADD;
		a_re      = '0;
		a_im      = '0;
		b_re      = '0;
		b_im      = '0;
		// hold reset low, then release it at a falling edge
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		test_corner_requests();
		test_mixed_random();
		test_back_to_back();
		test_drain_pauses();
		test_heavy_backpressure();

		// drain, then keep the receiver open long enough to catch strays
		wait_pipeline_empty();
		stall_level = STALL_NONE;
		repeat (2 * PIPE_LATENCY) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("complex_arithmetic_unit_core regression: pass");
		end else begin
			$display("complex_arithmetic_unit_core regression: fail");
		end
		$finish;
	end

endmodule
